// ===== src/cgr_pkg.sv =====
// Shared constants, state encoding and unit control type for the CRT rebuild block.
// No dependencies; compile first.
package cgr_pkg;

	localparam int MAX_MODULI = 4;
	localparam int MOD_W      = 16;
	localparam int VAL_W      = 64;
	localparam int CNT_W      = $clog2(MAX_MODULI + 1);
	localparam int STEP_W     = $clog2(VAL_W + 1);
	localparam int ITER_W     = $clog2(MOD_W);

	// serial units: a clear step, MOD_W shift steps, then the result is read
	localparam logic [STEP_W-1:0] UNIT_END  = STEP_W'(MOD_W + 1);
	localparam logic [STEP_W-1:0] RED_END   = STEP_W'(VAL_W);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MOD_W - 1);

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_EXP,
		ST_CORR,
		ST_MULT,
		ST_FINISH
	} cgr_state_t;

	typedef struct packed {
		logic clr;
		logic en;
	} cgr_ctl_t;

endpackage

// ===== src/cgr_req_if.sv =====
// Input channel: residue, modulus and last flag with valid/ready.
// Depends on cgr_pkg.
interface cgr_req_if import cgr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MOD_W-1:0] residue;
	logic [MOD_W-1:0] modulus;
	logic             is_last;

	modport source (output valid, residue, modulus, is_last, input ready);
	modport sink (input valid, residue, modulus, is_last, output ready);
endinterface

// ===== src/cgr_rsp_if.sv =====
// Result channel: rebuilt value and status with valid/ready.
// Depends on cgr_pkg.
interface cgr_rsp_if import cgr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;
	logic             status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

// ===== src/cgr_mod_red.sv =====
// Bit-serial reduction of a word, MSB first, by a 16-bit modulus.
// Depends on cgr_pkg.
module cgr_mod_red import cgr_pkg::*; (
	input  logic             clk,
	input  cgr_ctl_t         ctl,
	input  logic             bit_in,
	input  logic [MOD_W-1:0] m,
	output logic [MOD_W-1:0] r
);
	logic [MOD_W-1:0] r_q;
	logic [MOD_W:0]   t;
	logic [MOD_W-1:0] r_nxt;

	// remainder stays below m, so 2r+1 < 2m: one subtract suffices
	always_comb begin
		t = {r_q, bit_in};
		if (t >= {1'b0, m})
			r_nxt = MOD_W'(t - {1'b0, m});
		else
			r_nxt = t[MOD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.clr)
			r_q <= '0;
		else if (ctl.en)
			r_q <= r_nxt;
	end

	assign r = r_q;
endmodule

// ===== src/cgr_mod_mul.sv =====
// Interleaved modular multiplier: one bit of a per cycle while enabled, MSB first.
// Depends on cgr_pkg. Operands must be below m.
module cgr_mod_mul import cgr_pkg::*; (
	input  logic             clk,
	input  cgr_ctl_t         ctl,
	input  logic [MOD_W-1:0] a,
	input  logic [MOD_W-1:0] b,
	input  logic [MOD_W-1:0] m,
	output logic [MOD_W-1:0] r
);
	logic [MOD_W-1:0] a_q;
	logic [MOD_W-1:0] r_q;
	logic [MOD_W:0]   t1;
	logic [MOD_W-1:0] u1;
	logic [MOD_W:0]   t2;
	logic [MOD_W-1:0] r_nxt;

	always_comb begin
		t1 = {r_q, 1'b0};
		if (t1 >= {1'b0, m})
			u1 = MOD_W'(t1 - {1'b0, m});
		else
			u1 = t1[MOD_W-1:0];
		t2 = {1'b0, u1} + (a_q[MOD_W-1] ? {1'b0, b} : '0);
		if (t2 >= {1'b0, m})
			r_nxt = MOD_W'(t2 - {1'b0, m});
		else
			r_nxt = t2[MOD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			a_q <= a;
			r_q <= '0;
		end else if (ctl.en) begin
			a_q <= a_q << 1;
			r_q <= r_nxt;
		end
	end

	assign r = r_q;
endmodule

// ===== src/cgr_ser_mul.sv =====
// Shift-add multiplier: 16-bit multiplier MSB first into a 64-bit product, wrapping.
// Depends on cgr_pkg.
module cgr_ser_mul import cgr_pkg::*; (
	input  logic             clk,
	input  cgr_ctl_t         ctl,
	input  logic [MOD_W-1:0] mplier,
	input  logic [VAL_W-1:0] mcand,
	output logic [VAL_W-1:0] prod
);
	logic [MOD_W-1:0] mp_q;
	logic [VAL_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			mp_q  <= mplier;
			acc_q <= '0;
		end else if (ctl.en) begin
			mp_q  <= mp_q << 1;
			acc_q <= (acc_q << 1) + (mp_q[MOD_W-1] ? mcand : '0);
		end
	end

	assign prod = acc_q;
endmodule

// ===== src/crt_garner_reconstruct.sv =====
// Garner CRT reconstruction, one (residue, modulus) transaction at a time.
// Per pair: the first pair or an extra pair goes straight to finish, a modulus below two
// skips to the multiply, and any other pair passes the 64-bit serial reduction, the
// sixteen square-and-multiply rounds (clear, 16 steps, read), the correction and the multiply.
// Only one pair is in flight; the next is accepted once the block is back in idle.
// arst_n clears the set state (value 0, product 1, count 0) and the result valid flag.
module crt_garner_reconstruct import cgr_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	cgr_req_if.sink   req,
	cgr_rsp_if.source rsp
);
	cgr_state_t state_q, state_nxt;

	// set state
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;

	// captured transaction
	logic [MOD_W-1:0] mod_q;
	logic             last_q;

	// sequencing
	logic [STEP_W-1:0] step_q;
	logic [ITER_W-1:0] iter_q;

	// serial feeds and working values
	logic [VAL_W-1:0] vsh_q, psh_q, rsh_q;
	logic [MOD_W-1:0] acc_q, base_q, diff_q, corr_q;
	logic [MOD_W-1:0] exp_e;

	// result register
	logic             out_v_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_status_q;

	cgr_ctl_t red_ctl, mm_ctl, sm_ctl;
	logic [MOD_W-1:0] vr, pr, rr, mma_r, mmb_r, mma_a, mma_b;
	logic [VAL_W-1:0] cp_prod, mp_prod;
	logic             req_fire, out_free, out_load, unit_done;
	logic [MOD_W:0]   diff_raw;
	logic [MOD_W-1:0] diff_nxt;

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_v_q || rsp.ready;
	assign out_load  = (state_q == ST_FINISH) && last_q && out_free;
	assign unit_done = (step_q == UNIT_END);
	assign exp_e     = mod_q - MOD_W'(2);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (cnt_q >= CNT_W'(MAX_MODULI) || cnt_q == '0)
						state_nxt = ST_FINISH;
					else if (req.modulus < MOD_W'(2))
						state_nxt = ST_MULT;
					else
						state_nxt = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (step_q == RED_END)
					state_nxt = ST_EXP;
			end
			ST_EXP: begin
				if (unit_done && iter_q == ITER_LAST)
					state_nxt = ST_CORR;
			end
			ST_CORR: begin
				if (unit_done)
					state_nxt = ST_MULT;
			end
			ST_MULT: begin
				if (unit_done)
					state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!last_q || out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// unit controls and handshake outputs
	always_comb begin
		req.ready   = (state_q == ST_IDLE);
		red_ctl.clr = (state_q == ST_IDLE);
		red_ctl.en  = (state_q == ST_REDUCE) && (step_q != RED_END);
		mm_ctl.clr  = (state_q == ST_EXP || state_q == ST_CORR) && (step_q == '0);
		mm_ctl.en   = (state_q == ST_EXP || state_q == ST_CORR) && (step_q != '0) && !unit_done;
		sm_ctl.clr  = (state_q == ST_MULT) && (step_q == '0);
		sm_ctl.en   = (state_q == ST_MULT) && (step_q != '0) && !unit_done;
		mma_a       = acc_q;
		mma_b       = (state_q == ST_CORR) ? diff_q : base_q;
	end

	// difference of residues, taken non-negative modulo the modulus
	always_comb begin
		diff_raw = {1'b0, rr} + {1'b0, mod_q} - {1'b0, vr};
		if (diff_raw >= {1'b0, mod_q})
			diff_nxt = MOD_W'(diff_raw - {1'b0, mod_q});
		else
			diff_nxt = diff_raw[MOD_W-1:0];
	end

	cgr_mod_red u_red_v (.clk, .ctl(red_ctl), .bit_in(vsh_q[VAL_W-1]), .m(mod_q), .r(vr));
	cgr_mod_red u_red_p (.clk, .ctl(red_ctl), .bit_in(psh_q[VAL_W-1]), .m(mod_q), .r(pr));
	cgr_mod_red u_red_r (.clk, .ctl(red_ctl), .bit_in(rsh_q[VAL_W-1]), .m(mod_q), .r(rr));

	cgr_mod_mul u_mm_a (.clk, .ctl(mm_ctl), .a(mma_a), .b(mma_b), .m(mod_q), .r(mma_r));
	cgr_mod_mul u_mm_b (.clk, .ctl(mm_ctl), .a(base_q), .b(base_q), .m(mod_q), .r(mmb_r));

	cgr_ser_mul u_sm_c (.clk, .ctl(sm_ctl), .mplier(corr_q), .mcand(prod_q), .prod(cp_prod));
	cgr_ser_mul u_sm_m (.clk, .ctl(sm_ctl), .mplier(mod_q), .mcand(prod_q), .prod(mp_prod));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			val_q   <= '0;
			prod_q  <= VAL_W'(1);
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			step_q  <= '0;
			iter_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// a new result takes precedence over the retiring one
			if (out_load)
				out_v_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					iter_q <= '0;
					if (req_fire) begin
						// extra pair: drop it and flag the set; first pair: load directly
						if (cnt_q >= CNT_W'(MAX_MODULI)) begin
							ovf_q <= 1'b1;
						end else if (cnt_q == '0) begin
							val_q  <= VAL_W'(req.residue);
							prod_q <= VAL_W'(req.modulus);
							cnt_q  <= CNT_W'(1);
						end
					end
				end
				ST_REDUCE: begin
					step_q <= (step_q == RED_END) ? '0 : step_q + STEP_W'(1);
				end
				ST_EXP: begin
					if (unit_done) begin
						step_q <= '0;
						iter_q <= iter_q + ITER_W'(1);
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_CORR, ST_MULT: begin
					step_q <= unit_done ? '0 : step_q + STEP_W'(1);
					if (state_q == ST_MULT && unit_done) begin
						val_q  <= val_q + cp_prod;
						prod_q <= mp_prod;
						cnt_q  <= cnt_q + CNT_W'(1);
					end
				end
				ST_FINISH: begin
					// on the last pair, clear the set once the result register is free
					if (out_load) begin
						val_q   <= '0;
						prod_q  <= VAL_W'(1);
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mod_q  <= req.modulus;
			last_q <= req.is_last;
			vsh_q  <= val_q;
			psh_q  <= prod_q;
			rsh_q  <= VAL_W'(req.residue);
			corr_q <= '0;
		end
		if (red_ctl.en) begin
			vsh_q <= vsh_q << 1;
			psh_q <= psh_q << 1;
			rsh_q <= rsh_q << 1;
		end
		if (state_q == ST_REDUCE && step_q == RED_END) begin
			base_q <= pr;
			diff_q <= diff_nxt;
			acc_q  <= MOD_W'(1);
		end
		if (state_q == ST_EXP && unit_done) begin
			if (exp_e[iter_q])
				acc_q <= mma_r;
			base_q <= mmb_r;
		end
		if (state_q == ST_CORR && unit_done)
			corr_q <= mma_r;
		if (out_load) begin
			out_value_q  <= ovf_q ? '0 : val_q;
			out_status_q <= ovf_q ? STATUS_OVERFLOW : STATUS_OK;
		end
	end

	assign rsp.valid  = out_v_q;
	assign rsp.value  = out_value_q;
	assign rsp.status = out_status_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_MODULI))
		else $error("pair count beyond bound");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CNT_W'(MAX_MODULI))
		else $error("overflow flagged before set was full");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (cnt_q == '0) && !ovf_q && out_v_q)
		else $error("set state not cleared on emit");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_REDUCE) |-> step_q <= UNIT_END)
		else $error("unit step counter overran");
`endif
endmodule
